// ----- rtl/core/sthit_pkg.sv -----
// ----------------------------------------------------------------------------
// sthit_pkg
// shared codes and constants for the segment / triangle hit test
// ----------------------------------------------------------------------------
package sthit_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_PATH_X   = 3'd3,
        CFG_PATH_Y   = 3'd4,
        CFG_PATH_Z   = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W = 3;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_HIT     = 2'd0,
        OUT_CULLED  = 2'd1,
        OUT_OUTSIDE = 2'd2,
        OUT_RANGE   = 2'd3
    } t_outcome;

    // result word width (hit + outcome padded to a byte)
    localparam int OUT_TDW = 8;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // partial product chunk width in the multipliers
    localparam int MUL_CHUNK = 32;

endpackage

// ----- rtl/core/sthit_front.sv -----
// ----------------------------------------------------------------------------
// sthit_front
// accepts triangles, forms edge and origin offset vectors, queues them
// ----------------------------------------------------------------------------
module sthit_front
    import sthit_pkg::*;
#(
    parameter int W   = 32,
    parameter int TDW = 288
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [TDW-1:0]         i_s_axis_tdata,
    input  logic signed [W-1:0]    i_org_x,
    input  logic signed [W-1:0]    i_org_y,
    input  logic signed [W-1:0]    i_org_z,
    output logic                   o_head_valid,
    output logic [9*(W+1)-1:0]     o_head,
    input  logic                   i_pop
);
    localparam int DW = W + 1;

    logic signed [W-1:0]  vin [9];
    logic signed [W-1:0]  org [3];
    logic signed [DW-1:0] dif [9];
    logic [9*DW-1:0]      wr_data;
    logic [9*DW-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_cnt;
    logic                 push, pop;

    assign org[0] = i_org_x;
    assign org[1] = i_org_y;
    assign org[2] = i_org_z;

    // unpack vertices and form e1 = b - a, e2 = c - a, s = origin - a
    always_comb begin
        for (int f = 0; f < 9; f++) begin
            vin[f] = i_s_axis_tdata[f*W +: W];
        end
        for (int i = 0; i < 3; i++) begin
            dif[i]     = DW'(vin[3+i]) - DW'(vin[i]);
            dif[3 + i] = DW'(vin[6+i]) - DW'(vin[i]);
            dif[6 + i] = DW'(org[i]) - DW'(vin[i]);
        end
        for (int f = 0; f < 9; f++) begin
            wr_data[f*DW +: DW] = dif[f];
        end
    end

    // queue control
    assign o_s_axis_tready = (r_cnt != (FIFO_AW+1)'(FIFO_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_head_valid    = (r_cnt != '0);
    assign pop             = i_pop && o_head_valid;
    assign o_head          = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= wr_data;
    end

endmodule

// ----- rtl/core/sthit_mul.sv -----
// ----------------------------------------------------------------------------
// sthit_mul
// two-stage signed multiplier, b split into chunks of partial products
// ----------------------------------------------------------------------------
module sthit_mul
    import sthit_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int PW  = AW + BW;
    localparam int NCH = (BW + MUL_CHUNK - 1) / MUL_CHUNK;

    logic signed [PW-1:0] r_pp [NCH];
    logic signed [PW-1:0] n_sum;
    logic signed [PW-1:0] r_p;

    // partial products, one per chunk of b
    for (genvar k = 0; k < NCH; k++) begin : g_pp
        localparam int LO = k * MUL_CHUNK;
        localparam int HI = (k == NCH - 1) ? BW - 1 : LO + MUL_CHUNK - 1;
        localparam int CW = HI - LO + 1;
        if (k == NCH - 1) begin : g_top
            logic signed [CW-1:0]    bk;
            logic signed [AW+CW-1:0] prod;
            assign bk   = i_b[HI:LO];
            assign prod = i_a * bk;
            always_ff @(posedge i_clk) begin
                if (i_en) r_pp[k] <= PW'(prod);
            end
        end else begin : g_low
            logic signed [CW:0]      bk;
            logic signed [AW+CW:0]   prod;
            assign bk   = {1'b0, i_b[HI:LO]};
            assign prod = i_a * bk;
            always_ff @(posedge i_clk) begin
                if (i_en) r_pp[k] <= PW'(prod);
            end
        end
    end

    // weighted sum of partials
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NCH; k++) begin
            n_sum = n_sum + (r_pp[k] <<< (k * MUL_CHUNK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_p <= n_sum;
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/sthit_back.sv -----
// ----------------------------------------------------------------------------
// sthit_back
// cross and dot products, range tests and result register
// ----------------------------------------------------------------------------
module sthit_back
    import sthit_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic signed [W-1:0]    i_dir_x,
    input  logic signed [W-1:0]    i_dir_y,
    input  logic signed [W-1:0]    i_dir_z,
    input  logic                   i_head_valid,
    input  logic [9*(W+1)-1:0]     i_head,
    output logic                   o_pop,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDW-1:0]     o_m_axis_tdata
);
    localparam int DW   = W + 1;
    localparam int PW1  = 2 * DW;
    localparam int CW   = PW1 + 1;
    localparam int PW2  = DW + CW;
    localparam int DOTW = PW2 + 2;
    localparam int HW   = 9 * DW;

    logic                   en;
    logic [7:1]             r_vld;
    logic [HW-1:0]          r_hd1, r_hd2, r_hd3;
    logic signed [DW-1:0]   dir [3];
    logic signed [DW-1:0]   h0e1 [3], h0e2 [3], h0s [3];
    logic signed [DW-1:0]   h3e1 [3], h3e2 [3], h3s [3];
    logic signed [PW1-1:0]  pm0 [3], pm1 [3], qm0 [3], qm1 [3];
    logic signed [CW-1:0]   r_p [3], r_q [3];
    logic signed [PW2-1:0]  dd [3], du [3], dv [3], dt [3];
    logic signed [DOTW-1:0] r_det, r_u, r_v, r_t;
    logic signed [DOTW-1:0] u_m_det, t_m_det;
    logic signed [DOTW+1:0] uv_m_det;
    logic                   r_det_pos, r_u_neg, r_u_gt, r_v_neg, r_uv_gt;
    logic                   r_t_pos, r_t_gt;
    t_outcome               n_outcome;
    logic                   r_out_valid;
    t_outcome               r_outcome;

    // whole pipe advances unless the result register is held
    assign en    = !r_out_valid || i_m_axis_tready;
    assign o_pop = en && i_head_valid;

    assign dir[0] = DW'(i_dir_x);
    assign dir[1] = DW'(i_dir_y);
    assign dir[2] = DW'(i_dir_z);

    // unpack queued vectors at entry and at the dot stage
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            h0e1[i] = i_head[i*DW +: DW];
            h0e2[i] = i_head[(3+i)*DW +: DW];
            h0s[i]  = i_head[(6+i)*DW +: DW];
            h3e1[i] = r_hd3[i*DW +: DW];
            h3e2[i] = r_hd3[(3+i)*DW +: DW];
            h3s[i]  = r_hd3[(6+i)*DW +: DW];
        end
    end

    // p = dir x e2, q = s x e1
    for (genvar i = 0; i < 3; i++) begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        sthit_mul #(.AW(DW), .BW(DW)) u_pm0 (
            .i_clk(i_clk), .i_en(en), .i_a(dir[J]), .i_b(h0e2[K]), .o_p(pm0[i]));
        sthit_mul #(.AW(DW), .BW(DW)) u_pm1 (
            .i_clk(i_clk), .i_en(en), .i_a(dir[K]), .i_b(h0e2[J]), .o_p(pm1[i]));
        sthit_mul #(.AW(DW), .BW(DW)) u_qm0 (
            .i_clk(i_clk), .i_en(en), .i_a(h0s[J]), .i_b(h0e1[K]), .o_p(qm0[i]));
        sthit_mul #(.AW(DW), .BW(DW)) u_qm1 (
            .i_clk(i_clk), .i_en(en), .i_a(h0s[K]), .i_b(h0e1[J]), .o_p(qm1[i]));
    end

    // cross differences and vector carry
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd1 <= i_head;
            r_hd2 <= r_hd1;
            r_hd3 <= r_hd2;
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= CW'(pm0[i]) - CW'(pm1[i]);
                r_q[i] <= CW'(qm0[i]) - CW'(qm1[i]);
            end
        end
    end

    // det = e1.p, u = s.p, v = dir.q, t = e2.q
    for (genvar i = 0; i < 3; i++) begin : g_dot
        sthit_mul #(.AW(DW), .BW(CW)) u_det (
            .i_clk(i_clk), .i_en(en), .i_a(h3e1[i]), .i_b(r_p[i]), .o_p(dd[i]));
        sthit_mul #(.AW(DW), .BW(CW)) u_u (
            .i_clk(i_clk), .i_en(en), .i_a(h3s[i]), .i_b(r_p[i]), .o_p(du[i]));
        sthit_mul #(.AW(DW), .BW(CW)) u_v (
            .i_clk(i_clk), .i_en(en), .i_a(dir[i]), .i_b(r_q[i]), .o_p(dv[i]));
        sthit_mul #(.AW(DW), .BW(CW)) u_t (
            .i_clk(i_clk), .i_en(en), .i_a(h3e2[i]), .i_b(r_q[i]), .o_p(dt[i]));
    end

    // dot sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= DOTW'(dd[0]) + DOTW'(dd[1]) + DOTW'(dd[2]);
            r_u   <= DOTW'(du[0]) + DOTW'(du[1]) + DOTW'(du[2]);
            r_v   <= DOTW'(dv[0]) + DOTW'(dv[1]) + DOTW'(dv[2]);
            r_t   <= DOTW'(dt[0]) + DOTW'(dt[1]) + DOTW'(dt[2]);
        end
    end

    // range compares
    assign u_m_det  = r_u - r_det;
    assign t_m_det  = r_t - r_det;
    assign uv_m_det = (DOTW+2)'(r_u) + (DOTW+2)'(r_v) - (DOTW+2)'(r_det);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det_pos <= !r_det[DOTW-1] && (r_det != '0);
            r_u_neg   <= r_u[DOTW-1];
            r_u_gt    <= !u_m_det[DOTW-1] && (u_m_det != '0);
            r_v_neg   <= r_v[DOTW-1];
            r_uv_gt   <= !uv_m_det[DOTW+1] && (uv_m_det != '0);
            r_t_pos   <= !r_t[DOTW-1] && (r_t != '0);
            r_t_gt    <= !t_m_det[DOTW-1] && (t_m_det != '0);
        end
    end

    // outcome decision
    always_comb begin
        priority if (!r_det_pos) begin
            n_outcome = OUT_CULLED;
        end else if (r_u_neg || r_u_gt || r_v_neg || r_uv_gt) begin
            n_outcome = OUT_OUTSIDE;
        end else if (!r_t_pos || r_t_gt) begin
            n_outcome = OUT_RANGE;
        end else begin
            n_outcome = OUT_HIT;
        end
    end

    // valid chain and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[6:1], i_head_valid};
            r_out_valid <= r_vld[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_outcome <= n_outcome;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDW-3)'(0), r_outcome, (r_outcome == OUT_HIT)};

endmodule

// ----- rtl/core/segment_triangle_hit_test_top.sv -----
// ----------------------------------------------------------------------------
// segment_triangle_hit_test_top
// division-free segment / front-face triangle hit test
// ----------------------------------------------------------------------------
// Takes one triangle per clock while the result side is not stalled and reports
// one result word per triangle, in order. A triangle passes a 4-entry queue and
// then an 8-stage pipeline (a chunked multiplier step and a difference register
// for the cross products, a chunked multiplier step and a sum register for the
// dot products, then compare and result registers); throughput is one triangle
// per cycle while the output is not stalled, set by the fully pipelined
// multipliers. Write the origin and path registers only while no triangle
// is in flight.
module segment_triangle_hit_test_top
    import sthit_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    // triangle words
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, zero pad
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // result words
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // hit, outcome from bit 0 up, zero pad
    output logic [OUT_TDW-1:0]            o_m_axis_tdata
);
    localparam int W   = COORD_WIDTH;
    localparam int TDW = ((9 * W + 7) / 8) * 8;

    logic signed [W-1:0]  r_org_x, r_org_y, r_org_z;
    logic signed [W-1:0]  r_dir_x, r_dir_y, r_dir_z;
    logic                 head_valid, pop;
    logic [9*(W+1)-1:0]   head;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                CFG_PATH_X:   r_dir_x <= i_cfg_data;
                CFG_PATH_Y:   r_dir_y <= i_cfg_data;
                CFG_PATH_Z:   r_dir_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and form difference vectors
    sthit_front #(.W(W), .TDW(TDW)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_org_x         (r_org_x),
        .i_org_y         (r_org_y),
        .i_org_z         (r_org_z),
        .o_head_valid    (head_valid),
        .o_head          (head),
        .i_pop           (pop)
    );

    // back: products, tests and result
    sthit_back #(.W(W)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dir_x         (r_dir_x),
        .i_dir_y         (r_dir_y),
        .i_dir_z         (r_dir_z),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ----- dv/tb_segment_triangle_hit_test_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_triangle_hit_test_top
// self-checking bench for the segment / triangle hit test
// ----------------------------------------------------------------------------
// Streams triangles against several origin / path settings. Each accepted
// triangle is run through an exact wide-integer copy of the hit test, and
// the expected result word is queued. Every result word is checked in order.
// A directed table comes first, then random triangles, most of them built
// around the segment so that all outcomes turn up. Both sides idle at random.
module tb_segment_triangle_hit_test_top;
    import sthit_pkg::*;

    localparam int CW      = 32;
    localparam int TDW     = ((9*CW+7)/8)*8;
    localparam int N_RAND  = 1100;
    localparam int LIMIT   = 400000;
    localparam int DRAIN   = 30;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [159:0]   t_wide;
    typedef struct packed {
        logic     hit;
        t_outcome outcome;
    } t_verdict;
    typedef struct {
        t_coord    v[9];
        logic      known;
        t_verdict  want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [TDW-1:0]       i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [OUT_TDW-1:0]   o_m_axis_tdata;

    segment_triangle_hit_test_top #(.COORD_WIDTH(CW)) u_top (.*);

    // segment state mirrored from the register writes
    t_coord   seg_org[3];
    t_coord   seg_dir[3];
    t_verdict verdict_q[$];
    int       n_err;
    int       cycles;
    bit       idle_on;
    int       stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // exact hit test on sign-extended wide integers
    function automatic t_verdict hit_test(input t_coord tri_v[9]);
        t_wide    a[3], e1[3], e2[3], s[3], d[3], p[3], q[3];
        t_wide    det, u, v, t;
        t_verdict r;
        for (int i = 0; i < 3; i++) begin
            a[i]  = tri_v[i];
            e1[i] = t_wide'(tri_v[3+i]) - a[i];
            e2[i] = t_wide'(tri_v[6+i]) - a[i];
            s[i]  = t_wide'(seg_org[i]) - a[i];
            d[i]  = seg_dir[i];
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
        u   = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
        v   = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        t   = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        if (det <= 0)
            r.outcome = OUT_CULLED;
        else if (u < 0 || u > det || v < 0 || u + v > det)
            r.outcome = OUT_OUTSIDE;
        else if (t <= 0 || t > det)
            r.outcome = OUT_RANGE;
        else
            r.outcome = OUT_HIT;
        r.hit = (r.outcome == OUT_HIT);
        return r;
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input t_coord val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx <= CFG_ORIGIN_Z) seg_org[idx] = val;
        else seg_dir[idx - CFG_PATH_X] = val;
    endtask

    task automatic set_segment(input t_coord o[3], input t_coord d[3]);
        for (int i = 0; i < 3; i++) cfg_write(t_cfg_idx'(i), o[i]);
        for (int i = 0; i < 3; i++) cfg_write(t_cfg_idx'(3 + i), d[i]);
    endtask

    // drop valid, wait until every result is back, then a little more
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // send one triangle word; the expectation is queued at acceptance
    // valid stays high on return so words can follow back to back
    task automatic send_triangle(input t_row row);
        t_verdict       exp_v;
        logic [TDW-1:0] word;
        while (idle_on && $urandom_range(99) < 19) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        word = '0;
        for (int i = 0; i < 9; i++) word[i*CW +: CW] = row.v[i];
        i_s_axis_tdata  <= word;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        exp_v = hit_test(row.v);
        if (row.known && exp_v != row.want)
            $display("%0t: table row disagrees with predictor %p %p", $time, row.want, exp_v);
        verdict_q.insert(verdict_q.size(), row.known ? row.want : exp_v);
        @(negedge i_clk);
    endtask

    function automatic t_coord rnd_coord();
        case ($urandom_range(3))
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(1 << 21)) - (1 << 20));
            2: return t_coord'($signed($urandom_range(1 << 18)) - (1 << 17));
            default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    // triangle built around the point origin + f * path, mostly near the segment
    function automatic t_row near_triangle();
        t_row   r;
        t_coord ctr[3];
        int     f, spread;
        f      = $urandom_range(1600) - 300;
        spread = 1 << $urandom_range(16, 4);
        for (int i = 0; i < 3; i++)
            ctr[i] = seg_org[i] + t_coord'((longint'(seg_dir[i]) * f) / 1000);
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                r.v[3*k+i] = ctr[i] + t_coord'($signed($urandom_range(2*spread)) - spread);
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // result side: random stall and in-order check
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_m_axis_tready <= !(idle_on && $urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_verdict got, exp_v;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.hit     = o_m_axis_tdata[0];
            got.outcome = t_outcome'(o_m_axis_tdata[2:1]);
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_m_axis_tdata);
                n_err++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (got.hit !== exp_v.hit) begin
                    $display("%0t: hit exp %0b got %0b", $time, exp_v.hit, got.hit);
                    n_err++;
                end
                if (got.outcome !== exp_v.outcome) begin
                    $display("%0t: outcome exp %s got %0d", $time, exp_v.outcome.name(),
                             got.outcome);
                    n_err++;
                end
                if (o_m_axis_tdata[OUT_TDW-1:3] !== '0) begin
                    $display("%0t: pad exp 0 got %h", $time, o_m_axis_tdata[OUT_TDW-1:3]);
                    n_err++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row   tbl[$];
        t_row   r;
        t_coord o[3], d[3];
        n_err           = 0;
        cycles          = 0;
        idle_on         = 1'b0;
        stall_pct       = 19;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        for (int i = 0; i < 3; i++) begin
            seg_org[i] = '0;
            seg_dir[i] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset the path is zero, so everything is culled
        r.known = 1'b1;
        r.want  = '{1'b0, OUT_CULLED};
        r.v     = '{default: 32'sh0001_0000};
        tbl.insert(tbl.size(), r);
        r.v     = '{default: 32'sh7fff_ffff};
        tbl.insert(tbl.size(), r);
        foreach (tbl[i]) send_triangle(tbl[i]);
        drain();
        tbl.delete();

        // path along +z from z=-1 to z=+1, unit triangle in z=0 plane
        set_segment('{0, 0, -32'sh1_0000}, '{0, 0, 32'sh2_0000});
        r.known = 1'b1;
        // front face (ccw seen from below) centered at the axis: hit
        r.v = '{-32'sh1_0000, -32'sh1_0000, 0, 0, 32'sh1_0000, 0, 32'sh1_0000, 0, 0};
        r.want = '{1'b1, OUT_HIT};
        tbl.insert(tbl.size(), r);
        // same triangle wound the other way: back face
        r.v = '{-32'sh1_0000, -32'sh1_0000, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0};
        r.want = '{1'b0, OUT_CULLED};
        tbl.insert(tbl.size(), r);
        // off to the side: outside
        r.v = '{32'sh5_0000, 32'sh5_0000, 0, 32'sh5_0000, 32'sh7_0000, 0,
                32'sh7_0000, 32'sh5_0000, 0};
        r.want = '{1'b0, OUT_OUTSIDE};
        tbl.insert(tbl.size(), r);
        // vertex exactly on the axis: edges count as inside
        r.v = '{0, 0, 0, 0, 32'sh1_0000, 0, 32'sh1_0000, 0, 0};
        r.want = '{1'b1, OUT_HIT};
        tbl.insert(tbl.size(), r);
        // plane beyond the end point
        r.v = '{-32'sh1_0000, -32'sh1_0000, 32'sh3_0000, 0, 32'sh1_0000, 32'sh3_0000,
                32'sh1_0000, 0, 32'sh3_0000};
        r.want = '{1'b0, OUT_RANGE};
        tbl.insert(tbl.size(), r);
        // plane exactly at the end point: hit
        r.v = '{-32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 0, 32'sh1_0000, 32'sh1_0000,
                32'sh1_0000, 0, 32'sh1_0000};
        r.want = '{1'b1, OUT_HIT};
        tbl.insert(tbl.size(), r);
        // plane exactly at the start point: miss
        r.v = '{-32'sh1_0000, -32'sh1_0000, -32'sh1_0000, 0, 32'sh1_0000, -32'sh1_0000,
                32'sh1_0000, 0, -32'sh1_0000};
        r.want = '{1'b0, OUT_RANGE};
        tbl.insert(tbl.size(), r);
        // plane behind the start
        r.v = '{-32'sh1_0000, -32'sh1_0000, -32'sh4_0000, 0, 32'sh1_0000, -32'sh4_0000,
                32'sh1_0000, 0, -32'sh4_0000};
        r.want = '{1'b0, OUT_RANGE};
        tbl.insert(tbl.size(), r);
        // degenerate triangle
        r.v = '{default: 32'sh1234_5678};
        r.want = '{1'b0, OUT_CULLED};
        tbl.insert(tbl.size(), r);
        // extremes, predictor only
        r.known = 1'b0;
        r.v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff};
        tbl.insert(tbl.size(), r);
        r.v = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
        tbl.insert(tbl.size(), r);
        r.v = '{-1, -1, -1, 32'sh8000_0000, 0, 32'sh7fff_ffff, 0, 32'sh8000_0000, -1};
        tbl.insert(tbl.size(), r);
        foreach (tbl[i]) send_triangle(tbl[i]);
        drain();

        // extreme segment registers
        set_segment('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000},
                    '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
        foreach (tbl[i]) begin
            r = tbl[i];
            r.known = 1'b0;
            send_triangle(r);
        end
        drain();

        // random phases, each with its own segment
        idle_on = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < 3; i++) begin
                o[i] = (ph % 3 == 0) ? rnd_coord()
                                     : t_coord'($signed($urandom_range(1 << 22)) - (1 << 21));
                d[i] = (ph % 3 == 0) ? rnd_coord()
                                     : t_coord'($signed($urandom_range(1 << 22)) - (1 << 21));
            end
            set_segment(o, d);
            // one phase with no idling at all
            idle_on   = (ph != 4);
            stall_pct = idle_on ? 19 : 0;
            for (int n = 0; n < N_RAND / 8; n++) begin
                if ($urandom_range(99) < 80) begin
                    r = near_triangle();
                    // swap b and c half the time to flip the winding
                    if ($urandom_range(1))
                        for (int i = 0; i < 3; i++) begin
                            r.v[3+i] ^= r.v[6+i];
                            r.v[6+i] ^= r.v[3+i];
                            r.v[3+i] ^= r.v[6+i];
                        end
                end else begin
                    r.known = 1'b0;
                    for (int i = 0; i < 9; i++) r.v[i] = rnd_coord();
                end
                send_triangle(r);
            end
            drain();
        end

        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
